[sv/rar_pkg.sv]
// ----------------------------------------------------------------------------
// rar_pkg
// shared types and constants for the rational arithmetic reduce unit
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 32;
    localparam int EXT_W     = 64;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MUL_P0 = 2'd0,
        MUL_P1 = 2'd1,
        MUL_P2 = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     combine;
        logic     gcd_load;
        logic     gcd_step;
        logic     div_load;
        logic     div_step;
        logic     finish;
    } rar_ctl_t;

    typedef struct packed {
        logic skip;
        logic gcd_done;
        logic div_last;
    } rar_sts_t;

endpackage

[sv/rational_arithmetic_reduce_unit.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_reduce_unit
// sequence: done follows start via the multiply, combine and zero check states
//   when the combined numerator or denominator is zero, else also via the
//   binary gcd loop, the scale state and the bit-serial divider
// throughput: one transaction at a time; start is taken again from the cycle
//   that done is high; done is a single-cycle strobe, the receiver cannot stall
// reset: rst_n async active low returns to idle with no result pending
// ----------------------------------------------------------------------------
module rational_arithmetic_reduce_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // command side: transaction taken when start is high and busy is low
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            command,
    input  logic signed [OPERAND_WIDTH-1:0]       num_a,
    input  logic signed [OPERAND_WIDTH-1:0]       den_a,
    input  logic signed [OPERAND_WIDTH-1:0]       num_b,
    input  logic signed [OPERAND_WIDTH-1:0]       den_b,
    // result side: valid for the one cycle that done is high
    output logic                                  done,
    output logic signed [rar_pkg::NUM_OUT_W-1:0]  result_num,
    output logic signed [rar_pkg::DEN_OUT_W-1:0]  result_den,
    output logic                                  bad_operand
);
    import rar_pkg::*;

    // command and status between the sequencer and the datapath
    rar_ctl_t ctl;
    rar_sts_t sts;

    // sequencer: three shared multiplies, combine, zero check, gcd loop,
    // the scale state, then 2*OPERAND_WIDTH divider steps
    rar_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctl   (ctl),
        .sts   (sts)
    );

    // datapath: operands are captured on the accepting edge, so the command
    // ports are free once the transaction is taken; results hold until the
    // next transaction finishes
    rar_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .command     (command),
        .num_a       (num_a),
        .den_a       (den_a),
        .num_b       (num_b),
        .den_b       (den_b),
        .result_num  (result_num),
        .result_den  (result_den),
        .bad_operand (bad_operand),
        .done        (done)
    );

endmodule

[sv/rar_ctrl.sv]
// ----------------------------------------------------------------------------
// rar_ctrl
// sequencer: multiply, combine, binary gcd and divide phases
// ----------------------------------------------------------------------------
module rar_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output rar_pkg::rar_ctl_t ctl,
    input  rar_pkg::rar_sts_t sts
);
    import rar_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_MUL0    = 10'b00_0000_0010,
        S_MUL1    = 10'b00_0000_0100,
        S_MUL2    = 10'b00_0000_1000,
        S_COMBINE = 10'b00_0001_0000,
        S_CHECK   = 10'b00_0010_0000,
        S_GCD     = 10'b00_0100_0000,
        S_SCALE   = 10'b00_1000_0000,
        S_DIV     = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_P0;
                state_next  = S_MUL1;
            end
            S_MUL1:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_P1;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_P2;
                state_next  = S_COMBINE;
            end
            S_COMBINE:
            begin
                ctl.combine = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.skip)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.gcd_load = 1'b1;
                    state_next   = S_GCD;
                end
            end
            S_GCD:
            begin
                if (sts.gcd_done)
                begin
                    state_next = S_SCALE;
                end
                else
                begin
                    ctl.gcd_step = 1'b1;
                end
            end
            S_SCALE:
            begin
                ctl.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                ctl.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/rar_datapath.sv]
// ----------------------------------------------------------------------------
// rar_datapath
// shared multiplier, sign-magnitude combine, binary gcd, twin restoring divider
// ----------------------------------------------------------------------------
module rar_datapath #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rar_pkg::rar_ctl_t                     ctl,
    output rar_pkg::rar_sts_t                     sts,
    input  logic [1:0]                            command,
    input  logic signed [OPERAND_WIDTH-1:0]       num_a,
    input  logic signed [OPERAND_WIDTH-1:0]       den_a,
    input  logic signed [OPERAND_WIDTH-1:0]       num_b,
    input  logic signed [OPERAND_WIDTH-1:0]       den_b,
    output logic signed [rar_pkg::NUM_OUT_W-1:0]  result_num,
    output logic signed [rar_pkg::DEN_OUT_W-1:0]  result_den,
    output logic                                  bad_operand,
    output logic                                  done
);
    import rar_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * OPERAND_WIDTH;
    localparam int KW = $clog2(MW + 1);
    localparam int CW = $clog2(MW);

    // operand magnitudes and signs
    logic [W-1:0] a_raw, b_raw, c_raw, d_raw;
    logic [W-1:0] a_mag, b_mag, c_mag, d_mag;

    assign a_raw = num_a;
    assign b_raw = den_a;
    assign c_raw = num_b;
    assign d_raw = den_b;
    assign a_mag = a_raw[W-1] ? (~a_raw + 1'b1) : a_raw;
    assign b_mag = b_raw[W-1] ? (~b_raw + 1'b1) : b_raw;
    assign c_mag = c_raw[W-1] ? (~c_raw + 1'b1) : c_raw;
    assign d_mag = d_raw[W-1] ? (~d_raw + 1'b1) : d_raw;

    cmd_t         cmd_reg;
    logic [W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic         as_reg, bs_reg, cs_reg, ds_reg;
    logic         bad_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd_t'(command);
            a_reg   <= a_mag;
            b_reg   <= b_mag;
            c_reg   <= c_mag;
            d_reg   <= d_mag;
            as_reg  <= a_raw[W-1];
            bs_reg  <= b_raw[W-1];
            cs_reg  <= c_raw[W-1];
            ds_reg  <= d_raw[W-1];
            bad_reg <= (b_raw == '0) || (d_raw == '0)
                       || ((cmd_t'(command) == CMD_DIV) && (c_raw == '0));
        end
    end

    // shared multiplier
    logic [W-1:0]  mx, my;
    logic          mxs, mys;
    logic [MW-1:0] prod;

    always_comb
    begin
        case (ctl.mul_sel)
            MUL_P0:
            begin
                mx  = a_reg;
                mxs = as_reg;
                my  = (cmd_reg == CMD_MUL) ? c_reg : d_reg;
                mys = (cmd_reg == CMD_MUL) ? cs_reg : ds_reg;
            end
            MUL_P1:
            begin
                mx  = b_reg;
                mxs = bs_reg;
                my  = c_reg;
                mys = cs_reg;
            end
            MUL_P2:
            begin
                mx  = b_reg;
                mxs = bs_reg;
                my  = (cmd_reg == CMD_DIV) ? c_reg : d_reg;
                mys = (cmd_reg == CMD_DIV) ? cs_reg : ds_reg;
            end
            default:
            begin
                mx  = '0;
                mxs = 1'b0;
                my  = '0;
                mys = 1'b0;
            end
        endcase
    end

    assign prod = mx * my;

    logic [MW-1:0] p0_reg, p1_reg, p2_reg;
    logic          p0s_reg, p1s_reg, p2s_reg;
    logic          psign;

    assign psign = (prod != '0) && (mxs ^ mys);

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            case (ctl.mul_sel)
                MUL_P0:
                begin
                    p0_reg  <= prod;
                    p0s_reg <= psign;
                end
                MUL_P1:
                begin
                    p1_reg  <= prod;
                    p1s_reg <= psign;
                end
                default:
                begin
                    p2_reg  <= prod;
                    p2s_reg <= psign;
                end
            endcase
        end
    end

    // sign-magnitude add of the cross products
    logic          ys;
    logic [MW-1:0] sum_mag;
    logic          sum_neg;

    always_comb
    begin
        ys = p1s_reg;
        if (cmd_reg == CMD_SUB && p1_reg != '0)
        begin
            ys = ~p1s_reg;
        end
        if (p0s_reg == ys)
        begin
            sum_mag = p0_reg + p1_reg;
            sum_neg = p0s_reg;
        end
        else if (p0_reg >= p1_reg)
        begin
            sum_mag = p0_reg - p1_reg;
            sum_neg = p0s_reg;
        end
        else
        begin
            sum_mag = p1_reg - p0_reg;
            sum_neg = ys;
        end
        if (sum_mag == '0)
        begin
            sum_neg = 1'b0;
        end
    end

    // numerator and denominator; the magnitudes double as divider dividends
    logic [MW-1:0] n_mag_reg, q_mag_reg;
    logic          n_neg_reg, q_neg_reg;

    // binary gcd
    logic [MW-1:0] u_reg, v_reg, g_reg;
    logic [KW-1:0] k_reg;

    // divider
    logic [MW-1:0] rem_n_reg, rem_q_reg;
    logic [CW-1:0] cnt_reg;
    logic [MW:0]   sh_n, sh_q, g_ext;
    logic          ge_n, ge_q;

    assign g_ext = {1'b0, g_reg};
    assign sh_n  = {rem_n_reg, n_mag_reg[MW-1]};
    assign sh_q  = {rem_q_reg, q_mag_reg[MW-1]};
    assign ge_n  = (sh_n >= g_ext);
    assign ge_q  = (sh_q >= g_ext);

    always_ff @(posedge clk)
    begin
        if (ctl.combine)
        begin
            case (cmd_reg) inside
                CMD_ADD, CMD_SUB:
                begin
                    n_mag_reg <= sum_mag;
                    n_neg_reg <= sum_neg;
                end
                default:
                begin
                    n_mag_reg <= p0_reg;
                    n_neg_reg <= p0s_reg;
                end
            endcase
            q_mag_reg <= p2_reg;
            q_neg_reg <= p2s_reg;
        end
        else if (ctl.div_step)
        begin
            n_mag_reg <= {n_mag_reg[MW-2:0], ge_n};
            q_mag_reg <= {q_mag_reg[MW-2:0], ge_q};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.gcd_load)
        begin
            u_reg <= n_mag_reg;
            v_reg <= q_mag_reg;
            k_reg <= '0;
        end
        else if (ctl.gcd_step)
        begin
            if (!u_reg[0] && !v_reg[0])
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end
            else if (!u_reg[0])
            begin
                u_reg <= u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_reg <= v_reg >> 1;
            end
            else if (u_reg > v_reg)
            begin
                u_reg <= (u_reg - v_reg) >> 1;
            end
            else
            begin
                v_reg <= (v_reg - u_reg) >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.div_load)
        begin
            g_reg     <= u_reg << k_reg;
            rem_n_reg <= '0;
            rem_q_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (ctl.div_step)
        begin
            rem_n_reg <= ge_n ? MW'(sh_n - g_ext) : sh_n[MW-1:0];
            rem_q_reg <= ge_q ? MW'(sh_q - g_ext) : sh_q[MW-1:0];
            cnt_reg   <= cnt_reg + 1'b1;
        end
    end

    assign sts.skip     = (n_mag_reg == '0) || (q_mag_reg == '0);
    assign sts.gcd_done = (u_reg == v_reg);
    assign sts.div_last = (cnt_reg == CW'(MW - 1));

    // result registers
    logic [EXT_W-1:0] n_ext, q_ext;

    assign n_ext = n_neg_reg ? (EXT_W'(0) - EXT_W'(n_mag_reg)) : EXT_W'(n_mag_reg);
    assign q_ext = q_neg_reg ? (EXT_W'(0) - EXT_W'(q_mag_reg)) : EXT_W'(q_mag_reg);

    logic signed [NUM_OUT_W-1:0] num_out_reg;
    logic signed [DEN_OUT_W-1:0] den_out_reg;
    logic                        bad_out_reg;
    logic                        done_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            num_out_reg <= n_ext[NUM_OUT_W-1:0];
            den_out_reg <= q_ext[DEN_OUT_W-1:0];
            bad_out_reg <= bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.finish;
        end
    end

    assign result_num  = num_out_reg;
    assign result_den  = den_out_reg;
    assign bad_operand = bad_out_reg;
    assign done        = done_reg;

    // gcd never works on a zero operand, otherwise it would not terminate
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.gcd_step |-> (u_reg != '0) && (v_reg != '0))
        else $error("gcd step on zero operand");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_step |-> (g_reg != '0))
        else $error("divide by zero gcd");

    // gcd divides both values, so the last divide step leaves no remainder
    a_exact_div: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.div_step && sts.div_last) |=> (rem_n_reg == '0) && (rem_q_reg == '0))
        else $error("reduction left a remainder");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule
